// ----- rtl/sdl_pkg.sv -----
// Package for the sorted deque list: operation and status codes, controller states
// and the command bundle from the controller to the datapath. No dependencies.
`timescale 1ns / 1ps
package sdl_pkg;

	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_INSERT     = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_POP_BACK   = 3'd4,
		MODE_REMOVE     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
	} sdl_ctl_t;

endpackage

// ----- rtl/sdl_in_if.sv -----
// Request channel of the sorted deque list: one operation and its value per beat.
// No dependencies.
`timescale 1ns / 1ps
interface sdl_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic signed [31:0] item_value;

	modport source (output valid, output mode, output item_value, input ready);
	modport sink (input valid, input mode, input item_value, output ready);
endinterface

// ----- rtl/sdl_out_if.sv -----
// Response channel of the sorted deque list: status, removed value and count per beat.
// No dependencies.
`timescale 1ns / 1ps
interface sdl_out_if #(
	parameter int CNT_W = 5
);
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, output status, output removed_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input removed_value, input entry_count,
		output ready);
endinterface

// ----- rtl/sdl_dp.sv -----
// Datapath of the sorted deque list: the row of value cells, per-cell compares,
// position search by parallel prefix and the shift update. Depends on sdl_pkg.
`timescale 1ns / 1ps
module sdl_dp import sdl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sdl_ctl_t                 ctl,
	input  logic [2:0]               mode,
	input  logic signed [31:0]       item_value,
	output logic [1:0]               status,
	output logic signed [31:0]       removed_value,
	output logic [CNT_W-1:0]         entry_count
);

	localparam int LVLS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
		logic [DEPTH-1:0] p;
		p = v;
		for (int l = 0; l < LVLS; l++) begin
			p = p | (p << (1 << l));
		end
		return p;
	endfunction

	function automatic logic [DEPTH-1:0] first_one(input logic [DEPTH-1:0] v);
		return v & ~(prefix_or(v) << 1);
	endfunction

	logic [2:0]               mode_q;
	logic signed [31:0]       value_q;
	logic signed [31:0]       cells_q [DEPTH];
	logic signed [31:0]       cells_d [DEPTH];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic [DEPTH-1:0]         lt_s1;
	logic [DEPTH-1:0]         eq_s1;
	logic [1:0]               status_q;
	logic signed [31:0]       removed_q;

	logic [DEPTH-1:0]         valid_vec;
	logic [DEPTH-1:0]         at_cnt;
	logic [DEPTH-1:0]         is_back;
	logic [DEPTH-1:0]         ins_pos;
	logic [DEPTH-1:0]         rem_pos;
	logic [DEPTH-1:0]         after_ins;
	logic [DEPTH-1:0]         from_rem;
	logic                     do_ins;
	logic                     do_rem;
	logic                     full;
	logic                     empty;
	logic                     back_lt;
	logic                     back_eq;
	logic [1:0]               status_d;
	logic signed [31:0]       removed_d;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			valid_vec[i] = CNT_W'(i) < count_q;
			at_cnt[i]    = count_q == CNT_W'(i);
			is_back[i]   = count_q == CNT_W'(i + 1);
		end
	end

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign back_lt = |(is_back & lt_s1);
	assign back_eq = |(is_back & eq_s1);

	always_comb begin
		ins_pos  = '0;
		rem_pos  = '0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		status_d = STAT_OK;
		unique case (mode_q)
			MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					do_ins = 1'b1;
					if (mode_q == MODE_PUSH_FRONT || empty) begin
						ins_pos[0] = 1'b1;
					end else if (mode_q == MODE_PUSH_BACK) begin
						ins_pos = at_cnt;
					end else if (!lt_s1[0]) begin
						ins_pos[0] = 1'b1;
					end else if (back_lt) begin
						ins_pos = at_cnt;
					end else begin
						ins_pos = first_one(~lt_s1 & valid_vec);
					end
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else if (mode_q == MODE_POP_FRONT) begin
					do_rem     = 1'b1;
					rem_pos[0] = 1'b1;
				end else if (mode_q == MODE_POP_BACK) begin
					do_rem  = 1'b1;
					rem_pos = is_back;
				end else if (eq_s1[0]) begin
					do_rem     = 1'b1;
					rem_pos[0] = 1'b1;
				end else if (back_eq) begin
					do_rem  = 1'b1;
					rem_pos = is_back;
				end else begin
					rem_pos = first_one(eq_s1 & valid_vec);
					do_rem  = |rem_pos;
					if (!do_rem) begin
						status_d = STAT_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign after_ins = prefix_or(ins_pos) << 1;
	assign from_rem  = prefix_or(rem_pos);

	always_comb begin
		removed_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rem_pos[i]) begin
				removed_d = removed_d | cells_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cells_d[i] = cells_q[i];
			if (do_ins) begin
				if (ins_pos[i]) begin
					cells_d[i] = value_q;
				end else if (after_ins[i] && i > 0) begin
					cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_rem && from_rem[i] && i < DEPTH - 1) begin
				cells_d[i] = cells_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_ins) begin
			count_d = count_q + 1'b1;
		end else if (do_rem) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.commit) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mode_q  <= mode;
			value_q <= item_value;
		end
		if (ctl.compare) begin
			for (int i = 0; i < DEPTH; i++) begin
				lt_s1[i] <= cells_q[i] < value_q;
				eq_s1[i] <= cells_q[i] == value_q;
			end
		end
		if (ctl.commit) begin
			cells_q   <= cells_d;
			status_q  <= status_d;
			removed_q <= removed_d;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.commit |=> $stable(count_q))
		else $error("entry count changed outside an update");

endmodule

// ----- rtl/sdl_ctrl.sv -----
// Controller of the sorted deque list: sequences load, compare and update for each
// request and holds the response valid flag. Depends on sdl_pkg.
`timescale 1ns / 1ps
module sdl_ctrl import sdl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output sdl_ctl_t ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.load = in_valid;
			end
			ST_CMP: begin
				ctl.compare = 1'b1;
			end
			ST_UPD: begin
				ctl.commit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_then_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> ctl.compare)
		else $error("compare did not follow a load");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> out_valid_q && !in_ready || out_valid_q)
		else $error("update did not raise the response");

endmodule

// ----- rtl/sorted_deque_list.sv -----
// Top level of the sorted deque list: joins the controller and the datapath to the
// request and response channels. Depends on sdl_pkg, sdl_in_if, sdl_out_if, sdl_ctrl, sdl_dp.
//
// A bounded list of up to DEPTH signed 32-bit values that works as a deque and as an
// ordered list. Each request beat carries a mode and a value and yields exactly one
// response beat with a status, the value taken out and the entry count afterward. A
// request is captured first; then every cell compares its value with the request value
// in parallel; then the position is found and all cells shift together in the update.
// The next request is taken as soon as the update is done, even while the previous
// response still waits; the update waits only while the response register is full and
// is not being taken.
`timescale 1ns / 1ps
module sorted_deque_list import sdl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	sdl_in_if.sink    cmd,
	sdl_out_if.source rsp
);

	sdl_ctl_t ctl;

	sdl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl)
	);

	sdl_dp #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.mode          (cmd.mode),
		.item_value    (cmd.item_value),
		.status        (rsp.status),
		.removed_value (rsp.removed_value),
		.entry_count   (rsp.entry_count)
	);

endmodule

// ----- tb/sdl_checker.sv -----
// Response checker for the sorted deque list: watches the request and response beats,
// keeps its own copy of the list, and compares every response with its prediction.
// Depends on sdl_pkg.
`timescale 1ns / 1ps
module sdl_checker import sdl_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CNT_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         in_mode,
	input  logic signed [31:0] in_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         out_status,
	input  logic signed [31:0] out_removed,
	input  logic [CNT_W-1:0]   out_count,
	output int                 error_count,
	output int                 pending,
	output int                 checked,
	output int                 full_seen,
	output int                 empty_seen,
	output int                 missing_seen
);

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed;
		logic [CNT_W-1:0]   count;
	} response_t;

	logic signed [31:0] list_cells [DEPTH];
	int                 list_count;
	response_t          expected_q [$];

	function automatic response_t apply_request(logic [2:0] m, logic signed [31:0] v);
		response_t r;
		int        pos;
		int        i;
		bit        found;
		r.status  = STAT_OK;
		r.removed = '0;
		pos       = 0;
		found     = 1'b0;
		case (m)
			MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
				if (list_count >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					if (m == MODE_PUSH_FRONT) begin
						pos = 0;
					end else if (m == MODE_PUSH_BACK) begin
						pos = list_count;
					end else begin
						pos = list_count;
						if (list_count == 0 || list_cells[0] >= v ||
							list_cells[list_count-1] >= v) begin
							for (i = 0; i < list_count; i++) begin
								if (!found && list_cells[i] >= v) begin
									pos   = i;
									found = 1'b1;
								end
							end
						end
					end
					for (i = list_count; i > pos; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[pos] = v;
					list_count++;
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
				if (list_count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					found = 1'b1;
					if (m == MODE_POP_FRONT) begin
						pos = 0;
					end else if (m == MODE_POP_BACK) begin
						pos = list_count - 1;
					end else if (list_cells[0] == v) begin
						pos = 0;
					end else if (list_cells[list_count-1] == v) begin
						pos = list_count - 1;
					end else begin
						found = 1'b0;
						for (i = 0; i < list_count; i++) begin
							if (!found && list_cells[i] == v) begin
								pos   = i;
								found = 1'b1;
							end
						end
					end
					if (found) begin
						r.removed = list_cells[pos];
						for (i = pos; i + 1 < list_count; i++)
							list_cells[i] = list_cells[i+1];
						list_count--;
					end else begin
						r.status = STAT_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
		r.count = list_count[CNT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t want;
		if (!arst_n) begin
			list_count   = 0;
			expected_q.delete();
			error_count  = 0;
			checked      = 0;
			full_seen    = 0;
			empty_seen   = 0;
			missing_seen = 0;
			pending      = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("response beat with no request waiting");
					error_count++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (out_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_status);
						error_count++;
					end
					if (out_removed !== want.removed) begin
						$error("removed_value: expected %0d, got %0d", want.removed,
							out_removed);
						error_count++;
					end
					if (out_count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, out_count);
						error_count++;
					end
					case (want.status)
						STAT_FULL:      full_seen++;
						STAT_EMPTY:     empty_seen++;
						STAT_NOT_FOUND: missing_seen++;
						default: begin
						end
					endcase
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(apply_request(in_mode, in_value));
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the sorted deque list: clock, reset, request and response traffic
// with random gaps and long stalls, and the verdict. Depends on sdl_pkg, sdl_in_if,
// sdl_out_if, sorted_deque_list and sdl_checker.
`timescale 1ns / 1ps
module tb import sdl_pkg::*;;

	localparam int DEPTH        = 16;
	localparam int CNT_W        = 5;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT  = 600000;

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent_count;
	int   directed_count;
	int   error_count;
	int   pending;
	int   checked;
	int   full_seen;
	int   empty_seen;
	int   missing_seen;

	logic signed [31:0] recent_values [$];
	logic signed [31:0] edge_values [8];

	sdl_in_if                  cmd ();
	sdl_out_if #(.CNT_W(CNT_W)) rsp ();

	sorted_deque_list #(
		.DEPTH(DEPTH),
		.CNT_W(CNT_W)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	sdl_checker #(
		.DEPTH(DEPTH),
		.CNT_W(CNT_W)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd.valid),
		.in_ready    (cmd.ready),
		.in_mode     (cmd.mode),
		.in_value    (cmd.item_value),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_removed (rsp.removed_value),
		.out_count   (rsp.entry_count),
		.error_count (error_count),
		.pending     (pending),
		.checked     (checked),
		.full_seen   (full_seen),
		.empty_seen  (empty_seen),
		.missing_seen(missing_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d responses outstanding.", cycles,
			pending);
		$display("TB_ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [2:0] pick_mode(int phase);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 3'($urandom_range(6, 7));
		if (phase == 0)
			r = (r < 75) ? $urandom_range(0, 3) : $urandom_range(4, 6);
		else if (phase == 1)
			r = (r < 75) ? $urandom_range(4, 6) : $urandom_range(0, 3);
		else
			r = $urandom_range(0, 6);
		case (r)
			0:       return MODE_PUSH_FRONT;
			1:       return MODE_PUSH_BACK;
			2, 3:    return MODE_INSERT;
			4:       return MODE_POP_FRONT;
			5:       return MODE_POP_BACK;
			default: return MODE_REMOVE;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return edge_values[$urandom_range(0, 7)];
		else if (r < 65 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		else if (r < 80)
			return 32'($signed($urandom_range(0, 40)) - 20);
		else
			return $urandom;
	endfunction

	task automatic send_beat(input logic [2:0] m, input logic signed [31:0] v);
		int gap;
		cmd.valid      <= 1'b1;
		cmd.mode       <= m;
		cmd.item_value <= v;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		sent_count++;
		if (m <= MODE_INSERT) begin
			recent_values.push_back(v);
			if (recent_values.size() > 32)
				void'(recent_values.pop_front());
		end
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		int ready_run;
		int ready_gap;
		int hold_left;
		int holds_done;
		ready_run  = 0;
		ready_gap  = 0;
		hold_left  = 0;
		holds_done = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (holds_done < 2 && sent_count >= (holds_done == 0 ? 60 : 700)) begin
				rsp.ready <= 1'b0;
				hold_left = 250;
				holds_done++;
			end else if (ready_run > 0) begin
				rsp.ready <= 1'b1;
				ready_run--;
			end else if (ready_gap > 0) begin
				rsp.ready <= 1'b0;
				ready_gap--;
			end else begin
				rsp.ready <= 1'b1;
				ready_run = $urandom_range(0, 24);
				ready_gap = pick_gap();
			end
		end
	end

	initial begin
		int phase;
		int phase_left;
		int n;
		edge_values    = '{32'sh8000_0000, 32'sh8000_0001, -32'sd1, 32'sd0, 32'sd1, 32'sd7,
			32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
		sent_count     = 0;
		arst_n         = 1'b0;
		cmd.valid      <= 1'b0;
		cmd.mode       <= MODE_PUSH_FRONT;
		cmd.item_value <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_beat(MODE_POP_FRONT, 32'sd3);
		send_beat(MODE_POP_BACK, -32'sd3);
		send_beat(MODE_REMOVE, 32'sd5);
		send_beat(3'd6, 32'sh7FFF_FFFF);
		send_beat(3'd7, 32'sh8000_0000);
		send_beat(MODE_PUSH_FRONT, 32'sd0);
		send_beat(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
		send_beat(MODE_PUSH_FRONT, 32'sh8000_0000);
		send_beat(MODE_INSERT, 32'sh8000_0000);
		send_beat(MODE_INSERT, 32'sd0);
		send_beat(MODE_INSERT, 32'sh7FFF_FFFF);
		send_beat(MODE_INSERT, 32'sd1);
		send_beat(MODE_INSERT, -32'sd1);
		send_beat(MODE_REMOVE, 32'sd12345);
		send_beat(MODE_REMOVE, 32'sh8000_0000);
		send_beat(MODE_REMOVE, 32'sh7FFF_FFFF);
		send_beat(MODE_REMOVE, 32'sd0);
		send_beat(3'd6, 32'sd0);
		send_beat(MODE_POP_FRONT, 32'sd0);
		send_beat(MODE_POP_BACK, 32'sd0);
		send_beat(MODE_PUSH_BACK, -32'sd5);
		send_beat(MODE_REMOVE, -32'sd5);
		directed_count = sent_count;

		phase      = 0;
		phase_left = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase      = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 80);
			end
			phase_left--;
			send_beat(pick_mode(phase), pick_value());
		end
		cmd.valid <= 1'b0;

		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d request beats: %0d directed, the rest random fill, drain and mixed.",
			sent_count, directed_count);
		$display("Checked %0d responses (%0d full, %0d empty, %0d not found), %0d mismatches.",
			checked, full_seen, empty_seen, missing_seen, error_count);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/sdl_pkg.sv
rtl/sdl_in_if.sv
rtl/sdl_out_if.sv
rtl/sdl_dp.sv
rtl/sdl_ctrl.sv
rtl/sorted_deque_list.sv
tb/sdl_checker.sv
tb/tb.sv
